// ===== rtl/ecr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecr_pkg
// Shared word types and per-cell command bundle for the clock replacement
// block.
// ----------------------------------------------------------------------------
package ecr_pkg;

    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 4;
    localparam int FIU_W   = 5;
    localparam int FAULT_W = 32;

    typedef struct packed {
        logic [PAGE_W-1:0] page_number;
        logic              is_write;
        logic              last_access;
    } ecr_req_t;

    typedef struct packed {
        logic               page_fault;
        logic [FRAME_W-1:0] frame_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic               evicted_dirty;
        logic [FAULT_W-1:0] fault_total;
    } ecr_rsp_t;

    // Command broadcast along the row of frame cells
    typedef struct packed {
        logic clear_all;
        logic write_frame;
        logic hit_update;
        logic clear_use;
        logic is_write;
    } ecr_cmd_t;

endpackage

// ===== rtl/ecr_cell.sv =====
// ----------------------------------------------------------------------------
// ecr_cell
// One page frame: page tag, valid, use and dirty bits, plus one link of the
// first-match lookup chain.
// ----------------------------------------------------------------------------
module ecr_cell
    import ecr_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int IDX_W     = 4,
    parameter int PAGE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ecr_cmd_t             cmd,
    input  logic                 sel,
    input  logic                 en,
    input  logic [PAGE_BITS-1:0] page,
    input  logic                 hit_in,
    input  logic [IDX_W-1:0]     idx_in,
    output logic                 hit_out,
    output logic [IDX_W-1:0]     idx_out,
    output logic                 use_bit,
    output logic                 dirty_bit,
    output logic [PAGE_BITS-1:0] page_q
);

    logic                 valid_reg, valid_next;
    logic                 use_reg, use_next;
    logic                 dirty_reg, dirty_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 match;

    always_comb
    begin
        valid_next = valid_reg;
        use_next   = use_reg;
        dirty_next = dirty_reg;
        page_next  = page_reg;
        if (cmd.clear_all)
        begin
            valid_next = 1'b0;
            use_next   = 1'b0;
            dirty_next = 1'b0;
        end
        else if (sel && cmd.write_frame)
        begin
            page_next  = page;
            valid_next = 1'b1;
            use_next   = 1'b1;
            dirty_next = cmd.is_write;
        end
        else if (sel && cmd.hit_update)
        begin
            use_next   = 1'b1;
            dirty_next = dirty_reg | cmd.is_write;
        end
        else if (sel && cmd.clear_use)
        begin
            use_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            use_reg   <= 1'b0;
            dirty_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            use_reg   <= use_next;
            dirty_reg <= dirty_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    // Lowest matching frame wins: pass an earlier hit through unchanged
    assign match     = en && valid_reg && (page_reg == page);
    assign hit_out   = hit_in || match;
    assign idx_out   = hit_in ? idx_in : IDX_W'(INDEX);
    assign use_bit   = use_reg;
    assign dirty_bit = dirty_reg;
    assign page_q    = page_reg;

endmodule

// ===== rtl/enhanced_clock_replacement_top.sv =====
// ----------------------------------------------------------------------------
// enhanced_clock_replacement_top
// Enhanced second-chance clock page replacement over a row of frame cells.
// ----------------------------------------------------------------------------
// Usage: raise start with a request word while busy is low; the word is taken
// on that edge. Exactly one result word follows, shown for one cycle with
// result_valid high; the receiver cannot stall, so capture it then. A hit or
// a fill into a free frame is settled in the lookup state: the page ripples
// along the cell chain and the result word is registered from it. A fault
// that has to evict then walks the clock hand over the frames, one frame per
// cycle. With n managed frames (frames_in_use held to 1..MAX_FRAMES) the hand
// visits at most 3 x n + 1 frames: a seek pass, a sweep pass that strips
// every use bit, a second seek pass over all-dirty frames and the frame that
// is then taken. frames_in_use is written over the cfg channel while busy is
// low; a write empties every frame, clears the fault count and parks the hand
// on the last managed frame. Frames are empty after reset; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module enhanced_clock_replacement_top
    import ecr_pkg::*;
#(
    parameter int MAX_FRAMES = 16,
    parameter int PAGE_BITS  = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ecr_req_t         request,
    output logic             result_valid,
    output ecr_rsp_t         result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [FIU_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int FW    = (CNT_W > FIU_W) ? CNT_W : FIU_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_SEEK,
        S_SWEEP
    } state_t;

    // Clamp the register to the range of frames actually built
    function automatic logic [CNT_W-1:0] clamp_frames(input logic [FIU_W-1:0] v);
        logic [FW-1:0] ve;
        ve = FW'(v);
        if (ve == '0)
            return CNT_W'(1);
        else if (ve > FW'(MAX_FRAMES))
            return CNT_W'(MAX_FRAMES);
        else
            return CNT_W'(ve);
    endfunction

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] p,
                                                  input logic [IDX_W-1:0] last);
        return (p == last) ? '0 : p + IDX_W'(1);
    endfunction

    state_t             state_reg, state_next;
    ecr_req_t           req_reg, req_next;
    logic [FIU_W-1:0]   fiu_reg, fiu_next;
    logic [IDX_W-1:0]   hand_reg, hand_next;
    logic [IDX_W-1:0]   p_reg, p_next;
    logic [IDX_W-1:0]   begin_reg, begin_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [FAULT_W-1:0] fc_reg, fc_next;
    logic               result_valid_reg, result_valid_next;
    ecr_rsp_t           result_reg, result_next;

    logic [CNT_W-1:0]     n_act;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     p_adv;
    logic [IDX_W-1:0]     tgt;
    logic [FAULT_W-1:0]   fc_inc;
    logic [FAULT_W-1:0]   fc_out;
    logic                 finish;
    logic                 fault;
    logic                 evict;
    ecr_cmd_t             cmd;
    logic [MAX_FRAMES-1:0] sel;
    logic [MAX_FRAMES-1:0] en_vec;
    logic [MAX_FRAMES-1:0] use_vec;
    logic [MAX_FRAMES-1:0] dirty_vec;
    logic [PAGE_BITS-1:0]  page_arr [MAX_FRAMES];
    logic                  hit_chain [MAX_FRAMES+1];
    logic [IDX_W-1:0]      idx_chain [MAX_FRAMES+1];
    logic [PAGE_BITS+PAGE_W-1:0] in_ext;
    logic [PAGE_BITS-1:0]        page_in;
    logic [PAGE_BITS+PAGE_W-1:0] ev_ext;
    logic [IDX_W+FRAME_W-1:0]    frame_ext;

    assign n_act    = clamp_frames(fiu_reg);
    assign last_idx = IDX_W'(n_act - CNT_W'(1));
    assign p_adv    = next_idx(p_reg, last_idx);
    assign fc_inc   = (fc_reg == '1) ? fc_reg : fc_reg + FAULT_W'(1);

    // Drop page bits above PAGE_BITS, pad when PAGE_BITS is wider
    assign in_ext    = {{PAGE_BITS{1'b0}}, req_reg.page_number};
    assign page_in   = in_ext[PAGE_BITS-1:0];
    assign ev_ext    = {{PAGE_W{1'b0}}, page_arr[p_reg]};
    assign frame_ext = {{FRAME_W{1'b0}}, tgt};

    // ------------------------------------------------------------------------
    // Row of frame cells; the lookup result ripples from frame 0 upward
    // ------------------------------------------------------------------------
    assign hit_chain[0] = 1'b0;
    assign idx_chain[0] = '0;

    for (genvar i = 0; i < MAX_FRAMES; i++)
    begin : g_cell
        assign en_vec[i] = (CNT_W'(i) < n_act);

        ecr_cell #(
            .INDEX     (i),
            .IDX_W     (IDX_W),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .sel       (sel[i]),
            .en        (en_vec[i]),
            .page      (page_in),
            .hit_in    (hit_chain[i]),
            .idx_in    (idx_chain[i]),
            .hit_out   (hit_chain[i+1]),
            .idx_out   (idx_chain[i+1]),
            .use_bit   (use_vec[i]),
            .dirty_bit (dirty_vec[i]),
            .page_q    (page_arr[i])
        );
    end

    // ------------------------------------------------------------------------
    // Sequencer: lookup, then a hit update, a fill or a walking victim search
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        req_next          = req_reg;
        fiu_next          = fiu_reg;
        hand_next         = hand_reg;
        p_next            = p_reg;
        begin_next        = begin_reg;
        occ_next          = occ_reg;
        fc_next           = fc_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        cmd               = '0;
        cmd.is_write      = req_reg.is_write;
        tgt               = p_reg;
        finish            = 1'b0;
        fault             = 1'b0;
        evict             = 1'b0;
        fc_out            = fc_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    fiu_next      = cfg_data;
                    hand_next     = IDX_W'(clamp_frames(cfg_data) - CNT_W'(1));
                    occ_next      = '0;
                    fc_next       = '0;
                    cmd.clear_all = 1'b1;
                end
                if (start)
                begin
                    req_next   = request;
                    state_next = S_LOOKUP;
                end
            end

            S_LOOKUP:
            begin
                if (hit_chain[MAX_FRAMES])
                begin
                    finish         = 1'b1;
                    tgt            = idx_chain[MAX_FRAMES];
                    cmd.hit_update = 1'b1;
                end
                else if (occ_reg < n_act)
                begin
                    // Fill free frames in order; hold the hand
                    finish          = 1'b1;
                    fault           = 1'b1;
                    tgt             = occ_reg[IDX_W-1:0];
                    cmd.write_frame = 1'b1;
                    occ_next        = occ_reg + CNT_W'(1);
                end
                else
                begin
                    p_next     = next_idx(hand_reg, last_idx);
                    begin_next = next_idx(hand_reg, last_idx);
                    state_next = S_SEEK;
                end
            end

            S_SEEK:
            begin
                // Look for a frame neither used nor modified
                if (!use_vec[p_reg] && !dirty_vec[p_reg])
                begin
                    finish          = 1'b1;
                    fault           = 1'b1;
                    evict           = 1'b1;
                    cmd.write_frame = 1'b1;
                end
                else
                begin
                    p_next = p_adv;
                    if (p_adv == begin_reg)
                        state_next = S_SWEEP;
                end
            end

            S_SWEEP:
            begin
                // Take the first unused frame, clearing use bits on the way
                if (!use_vec[p_reg])
                begin
                    finish          = 1'b1;
                    fault           = 1'b1;
                    evict           = 1'b1;
                    cmd.write_frame = 1'b1;
                end
                else
                begin
                    cmd.clear_use = 1'b1;
                    p_next        = p_adv;
                    if (p_adv == begin_reg)
                        state_next = S_SEEK;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next        = S_IDLE;
            result_valid_next = 1'b1;
            if (evict)
                hand_next = p_reg;
            fc_out = fault ? fc_inc : fc_reg;
            result_next.page_fault    = fault;
            result_next.frame_index   = frame_ext[FRAME_W-1:0];
            result_next.evicted_valid = evict;
            result_next.evicted_page  = evict ? ev_ext[PAGE_W-1:0] : '0;
            result_next.evicted_dirty = evict && dirty_vec[p_reg];
            result_next.fault_total   = fc_out;
            fc_next = req_reg.last_access ? '0 : fc_out;
        end
    end

    // Steer the command to the one cell it concerns
    always_comb
    begin
        sel = '0;
        if (cmd.write_frame || cmd.hit_update || cmd.clear_use)
            sel[tgt] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            req_reg          <= '0;
            fiu_reg          <= FIU_W'(16);
            hand_reg         <= IDX_W'(clamp_frames(FIU_W'(16)) - CNT_W'(1));
            p_reg            <= '0;
            begin_reg        <= '0;
            occ_reg          <= '0;
            fc_reg           <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            req_reg          <= req_next;
            fiu_reg          <= fiu_next;
            hand_reg         <= hand_next;
            p_reg            <= p_next;
            begin_reg        <= begin_next;
            occ_reg          <= occ_next;
            fc_reg           <= fc_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(state_reg != S_IDLE))
        else $error("result word without a request in flight");

    a_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(hand_reg) < n_act)
        else $error("clock hand beyond the managed frames");

    a_occ_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= n_act)
        else $error("occupied count beyond the managed frames");

    a_evict_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.evicted_valid) |-> (occ_reg == n_act))
        else $error("eviction while free frames remain");

endmodule
